/* sv/hpf_pkg.sv */
// Shared types, constants and codes for the highest priority first gate.
package hpf_pkg;

  localparam int SLOT_W         = 4;
  localparam int PRIO_W         = 16;
  localparam int SLOT_CAP       = 16;
  localparam int DEF_NUM_QUEUES = 16;
  localparam int CFG_AW         = 4;
  localparam int CFG_DW         = 32;

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [SLOT_W-1:0]        slot_t;

  localparam prio_t RST_MIN_PRIO = prio_t'(-128);
  localparam prio_t RST_MAX_PRIO = prio_t'(127);
  localparam prio_t RST_DEF_PRIO = prio_t'(0);

  typedef enum logic [1:0] {
    REG_MIN_PRIO = 2'd0,
    REG_MAX_PRIO = 2'd1,
    REG_DEF_PRIO = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Running maximum wave handed from cell to cell
  typedef struct packed {
    logic  tok;
    prio_t best;
  } hpf_wave_t;

  // Priority write into one cell
  typedef struct packed {
    logic  en;
    prio_t value;
  } hpf_wr_t;

endpackage

/* sv/hpf_stream_if.sv */
// Valid/ready channels for input words and decision words.
interface hpf_in_if;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  hpf_pkg::slot_t       queue_slot;
  hpf_pkg::prio_t       priority_value;
  logic [15:0]          present_mask;
  logic [15:0]          ready_mask;

  modport source (output valid, cmd, queue_slot, priority_value, present_mask, ready_mask,
                  input ready);
  modport sink   (input valid, cmd, queue_slot, priority_value, present_mask, ready_mask,
                  output ready);
endinterface

interface hpf_out_if;
  logic           valid;
  logic           ready;
  hpf_pkg::slot_t target_slot;
  logic           resume;
  logic           last;

  modport source (output valid, target_slot, resume, last, input ready);
  modport sink   (input valid, target_slot, resume, last, output ready);
endinterface

/* sv/hpf_cell.sv */
// One queue slot: stored priority, set flag and one stage of the maximum wave.
module hpf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  hpf_pkg::hpf_wr_t   wr,
  input  hpf_pkg::prio_t     default_prio,
  input  logic               candidate,
  input  hpf_pkg::hpf_wave_t wave_in,
  output hpf_pkg::hpf_wave_t wave_out,
  input  hpf_pkg::prio_t     best_final,
  output logic               resume
);
  import hpf_pkg::*;

  prio_t     prio_r;
  logic      set_r;
  logic      tok_r;
  prio_t     best_r;
  prio_t     eff_prio;
  prio_t     best_nxt;

  assign eff_prio = set_r ? prio_r : default_prio;
  assign best_nxt = (candidate && (eff_prio > wave_in.best)) ? eff_prio : wave_in.best;
  assign resume   = (eff_prio >= best_final);
  assign wave_out = '{tok: tok_r, best: best_r};

  always_ff @(posedge clk) begin
    if (wr.en) begin
      prio_r <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r <= 1'b0;
      tok_r <= 1'b0;
    end else begin
      if (wr.en) begin
        set_r <= 1'b1;
      end
      tok_r <= wave_in.tok;
    end
  end

  // hold the running maximum once the wave has passed
  always_ff @(posedge clk) begin
    if (wave_in.tok) begin
      best_r <= best_nxt;
    end
  end

endmodule

/* sv/highest_priority_first_gate_unit.sv */
// Top level of the highest priority first gate: config port, sequencer, cell chain.
// A set word gives no decision. A scheduling word runs a
// maximum wave down the row of min(NUM_QUEUES, 16) slot cells, one cell per
// cycle, then steps through the slots one per cycle while the result side
// does not stall and emits a decision for every present queue. The sequencer
// takes a new word only when idle; the output register lets the last decision
// wait while the next word is taken.
module highest_priority_first_gate_unit #(
  parameter int NUM_QUEUES = hpf_pkg::DEF_NUM_QUEUES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hpf_in_if.sink                     in_if,
  hpf_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpf_pkg::CFG_AW-1:0] paddr,
  input  logic [hpf_pkg::CFG_DW-1:0] pwdata,
  output logic [hpf_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import hpf_pkg::*;

  localparam int SLOTS = (NUM_QUEUES < SLOT_CAP) ? NUM_QUEUES : SLOT_CAP;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  prio_t min_prio_r, max_prio_r, def_prio_r;
  logic  cfg_wr;
  reg_idx_t cfg_idx;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [SLOTS-1:0] present_r, ready_r;
  logic             start_r;

  hpf_wave_t wave [SLOTS+1];
  logic [SLOTS-1:0] resume_vec;
  logic [SLOTS-1:0] tok_vec;

  logic  accept, sched_go, set_go;
  logic  load_ok, load, advance, more_above;
  prio_t clamp_lo, clamp_val;

  logic  out_valid_r;
  slot_t out_slot_r;
  logic  out_resume_r, out_last_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_prio_r <= RST_MIN_PRIO;
      max_prio_r <= RST_MAX_PRIO;
      def_prio_r <= RST_DEF_PRIO;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_PRIO: min_prio_r <= prio_t'(pwdata[PRIO_W-1:0]);
        REG_MAX_PRIO: max_prio_r <= prio_t'(pwdata[PRIO_W-1:0]);
        REG_DEF_PRIO: def_prio_r <= prio_t'(pwdata[PRIO_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_PRIO: prdata = CFG_DW'(min_prio_r);
      REG_MAX_PRIO: prdata = CFG_DW'(max_prio_r);
      REG_DEF_PRIO: prdata = CFG_DW'(def_prio_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  assign accept   = in_if.valid && in_if.ready;
  assign sched_go = accept && (in_if.cmd == CMD_SCHED);
  assign set_go   = accept && (in_if.cmd == CMD_SET);

  // raise to the floor first, then lower to the ceiling
  assign clamp_lo  = (in_if.priority_value < min_prio_r) ? min_prio_r : in_if.priority_value;
  assign clamp_val = (clamp_lo > max_prio_r) ? max_prio_r : clamp_lo;

  always_ff @(posedge clk) begin
    if (sched_go) begin
      present_r <= in_if.present_mask[SLOTS-1:0];
      ready_r   <= in_if.ready_mask[SLOTS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      start_r <= sched_go;
    end
  end

  // ---------------- cell chain ----------------
  assign wave[0].tok  = start_r;
  assign wave[0].best = min_prio_r;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    hpf_wr_t cell_wr;
    assign cell_wr.en    = set_go && (in_if.queue_slot == SLOT_W'(i));
    assign cell_wr.value = clamp_val;
    assign tok_vec[i]    = wave[i+1].tok;

    hpf_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr           (cell_wr),
      .default_prio (def_prio_r),
      .candidate    (present_r[i] && ready_r[i]),
      .wave_in      (wave[i]),
      .wave_out     (wave[i+1]),
      .best_final   (wave[SLOTS].best),
      .resume       (resume_vec[i])
    );
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (sched_go) state_nxt = ST_SCAN;
      ST_SCAN: if (wave[SLOTS].tok) state_nxt = ST_EMIT;
      ST_EMIT: if (advance && (idx_r == IDX_W'(SLOTS-1))) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign load_ok = !out_valid_r || out_if.ready;

  always_comb begin
    in_if.ready = 1'b0;
    load        = 1'b0;
    advance     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_if.ready = 1'b1;
      ST_SCAN: ;
      ST_EMIT: begin
        load    = present_r[idx_r] && load_ok;
        advance = !present_r[idx_r] || load_ok;
      end
      default: ;
    endcase
  end

  always_comb begin
    more_above = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if ((IDX_W'(j) > idx_r) && present_r[j]) begin
        more_above = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (state_r != ST_EMIT) begin
      idx_r <= '0;
    end else if (advance && (idx_r != IDX_W'(SLOTS-1))) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r   <= SLOT_W'(idx_r);
      out_resume_r <= resume_vec[idx_r];
      out_last_r   <= !more_above;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.target_slot = out_slot_r;
  assign out_if.resume      = out_resume_r;
  assign out_if.last        = out_last_r;

  // ---------------- assertions ----------------
  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({start_r, tok_vec}))
    else $error("more than one maximum wave in the cell chain");

  a_idle_no_wave: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ({start_r, tok_vec} == '0))
    else $error("wave in the cell chain while idle");

  a_emit_after_wave: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (state_nxt == ST_EMIT)) |-> wave[SLOTS].tok)
    else $error("decisions started before the wave left the chain");

  a_load_present: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid_r && (state_r == ST_EMIT || state_r == ST_IDLE)))
    else $error("decision word loaded outside the emit phase");

endmodule
